### hw/rtl/rubi_pkg.sv
// Shared types, constants and float helpers for the ray/box slab test.
`timescale 1ns / 1ps
`default_nettype none
package rubi_pkg;

  localparam int NUM_STAGES   = 39;
  localparam int SLAB_STAGES  = 36;
  localparam int ADD_STAGES   = 4;
  localparam int DIV_FIRST    = 5;
  localparam int QUO_BITS     = 27;
  localparam int DIV_STAGES   = QUO_BITS + 3;
  localparam int SWAP_STAGE   = DIV_FIRST + DIV_STAGES;

  localparam logic [31:0] THR_RESET = 32'h3A83126F;
  localparam logic [31:0] F_NAN     = 32'h7FC00000;
  localparam logic [30:0] F_INF_MAG = 31'h7F800000;
  localparam logic [30:0] ONE_MAG   = 31'h3F800000;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_near;
    logic [31:0] t_far;
  } out_t;

  typedef struct packed {
    logic              par;
    logic              sgn;
    logic              inf;
    logic [23:0]       md;
    logic signed [9:0] edn;
  } dinfo_t;

  function automatic logic f_is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic [31:0] f_key(input logic [31:0] x);
    logic [31:0] y;
    y = (x[30:0] == 31'd0) ? 32'd0 : x;
    return y[31] ? ~y : {1'b1, y[30:0]};
  endfunction

  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    return !f_is_nan(a) && !f_is_nan(b) && (f_key(a) > f_key(b));
  endfunction

  function automatic logic f_ge(input logic [31:0] a, input logic [31:0] b);
    return !f_is_nan(a) && !f_is_nan(b) && (f_key(a) >= f_key(b));
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] c;
    logic       found;
    c = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        c = 5'(26 - i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rubi_add1.sv
// Four-stage single-precision adder computing 1.0 + x with round to nearest even.
`timescale 1ns / 1ps
`default_nettype none
module rubi_add1
  import rubi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [ADD_STAGES-1:0] en,
  input  wire logic [31:0]           x,
  output logic [31:0]                r
);

  logic        x_nan, x_inf, x_big;
  logic [23:0] mx, ma, mb;
  logic [7:0]  ex, ea, eb, sh;
  logic [4:0]  shc;
  logic [53:0] wide;
  logic        sa, sb;

  logic [26:0] a27_r, b27_r;
  logic        sub_r, sgn1_r, spec1_r;
  logic [7:0]  e1_r;
  logic [31:0] specv1_r;

  logic [27:0] sum_r;
  logic        sgn2_r, spec2_r;
  logic [7:0]  e2_r;
  logic [31:0] specv2_r;

  logic [26:0] n3_r;
  logic [4:0]  lz3_r;
  logic [8:0]  e3_r;
  logic        zero3_r, sgn3_r, spec3_r;
  logic [31:0] specv3_r;

  logic [26:0] ns;
  logic [8:0]  ee;
  logic        up;
  logic [30:0] mag;
  logic [31:0] r_nxt;
  logic [31:0] r_r;

  always_comb begin
    x_nan = (&x[30:23]) && (|x[22:0]);
    x_inf = (&x[30:23]) && !(|x[22:0]);
    x_big = x[30:0] >= ONE_MAG;
    mx    = {|x[30:23], x[22:0]};
    ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ma    = x_big ? mx : 24'h800000;
    ea    = x_big ? ex : 8'd127;
    mb    = x_big ? 24'h800000 : mx;
    eb    = x_big ? 8'd127 : ex;
    sa    = x_big ? x[31] : 1'b0;
    sb    = x_big ? 1'b0 : x[31];
    sh    = ea - eb;
    shc   = (sh > 8'd27) ? 5'd27 : sh[4:0];
    wide  = {mb, 3'b000, 27'd0} >> shc;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a27_r    <= {ma, 3'b000};
      b27_r    <= wide[53:27] | {26'd0, |wide[26:0]};
      sub_r    <= sa ^ sb;
      sgn1_r   <= sa;
      e1_r     <= ea;
      spec1_r  <= x_nan || x_inf;
      specv1_r <= x_nan ? F_NAN : x;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum_r    <= sub_r ? ({1'b0, a27_r} - {1'b0, b27_r}) : ({1'b0, a27_r} + {1'b0, b27_r});
      e2_r     <= e1_r;
      sgn2_r   <= sgn1_r;
      spec2_r  <= spec1_r;
      specv2_r <= specv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (sum_r[27]) begin
        n3_r  <= {sum_r[27:2], sum_r[1] | sum_r[0]};
        lz3_r <= 5'd0;
        e3_r  <= {1'b0, e2_r} + 9'd1;
      end else begin
        n3_r  <= sum_r[26:0];
        lz3_r <= lzc27(sum_r[26:0]);
        e3_r  <= {1'b0, e2_r};
      end
      zero3_r  <= (sum_r == 28'd0);
      sgn3_r   <= sgn2_r;
      spec3_r  <= spec2_r;
      specv3_r <= specv2_r;
    end
  end

  always_comb begin
    ns  = n3_r << lz3_r;
    ee  = e3_r - {4'd0, lz3_r};
    up  = ns[2] && (ns[1] || ns[0] || ns[3]);
    mag = {ee[7:0], ns[25:3]} + {30'd0, up};
    if (spec3_r) begin
      r_nxt = specv3_r;
    end else if (zero3_r) begin
      r_nxt = 32'd0;
    end else begin
      r_nxt = {sgn3_r, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r_r <= r_nxt;
    end
  end

  assign r = r_r;

endmodule
`default_nettype wire

### hw/rtl/rubi_div.sv
// Pipelined single-precision divider, one quotient bit per stage, with special cases.
`timescale 1ns / 1ps
`default_nettype none
module rubi_div
  import rubi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [DIV_STAGES-1:0] en,
  input  wire logic [31:0]           num,
  input  wire dinfo_t                dinf,
  output logic [31:0]                quo
);

  logic               n_nan, n_inf, n_zero, sx, spec0;
  logic [31:0]        specv0;
  logic signed [10:0] be0;

  logic [24:0]          rem_r   [0:QUO_BITS];
  logic [QUO_BITS-1:0]  q_r     [0:QUO_BITS];
  logic [23:0]          md_r    [0:QUO_BITS-1];
  logic signed [10:0]   be_r    [0:QUO_BITS];
  logic                 sgn_r   [0:QUO_BITS];
  logic                 spec_r  [0:QUO_BITS];
  logic [31:0]          specv_r [0:QUO_BITS];

  logic [26:0]        nrm_r;
  logic signed [10:0] be1_r;
  logic               st0_r, sgn1_r, spec1_r;
  logic [31:0]        specv1_r;

  logic signed [10:0] one_minus;
  logic [4:0]         sh;
  logic [57:0]        wide;
  logic [26:0]        ns;
  logic               st, up;
  logic [7:0]         ef;
  logic [30:0]        mag;
  logic [31:0]        quo_nxt;
  logic [31:0]        quo_r;

  always_comb begin
    n_nan  = f_is_nan(num);
    n_inf  = (&num[30:23]) && !(|num[22:0]);
    n_zero = (num[30:0] == 31'd0);
    sx     = num[31] ^ dinf.sgn;
    be0    = $signed({3'b000, num[30:23]}) - $signed({dinf.edn[9], dinf.edn}) + 11'sd127;
    spec0  = 1'b1;
    specv0 = F_NAN;
    priority if (dinf.par) begin
      specv0 = (n_nan || n_zero) ? F_NAN : {num[31], F_INF_MAG};
    end else if (n_nan) begin
      specv0 = F_NAN;
    end else if (n_inf) begin
      specv0 = dinf.inf ? F_NAN : {sx, F_INF_MAG};
    end else if (n_zero || dinf.inf) begin
      specv0 = {sx, 31'd0};
    end else begin
      spec0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]   <= {2'b01, num[22:0]};
      q_r[0]     <= '0;
      md_r[0]    <= dinf.md;
      be_r[0]    <= be0;
      sgn_r[0]   <= sx;
      spec_r[0]  <= spec0;
      specv_r[0] <= specv0;
    end
  end

  for (genvar gi = 0; gi < QUO_BITS; gi++) begin : g_step
    logic        ge;
    logic [24:0] diff;
    assign diff = rem_r[gi] - {1'b0, md_r[gi]};
    assign ge   = rem_r[gi] >= {1'b0, md_r[gi]};
    always_ff @(posedge clk) begin
      if (en[gi+1]) begin
        rem_r[gi+1]   <= ge ? {diff[23:0], 1'b0} : {rem_r[gi][23:0], 1'b0};
        q_r[gi+1]     <= {q_r[gi][QUO_BITS-2:0], ge};
        be_r[gi+1]    <= be_r[gi];
        sgn_r[gi+1]   <= sgn_r[gi];
        spec_r[gi+1]  <= spec_r[gi];
        specv_r[gi+1] <= specv_r[gi];
      end
    end
    if (gi < QUO_BITS - 1) begin : g_md
      always_ff @(posedge clk) begin
        if (en[gi+1]) begin
          md_r[gi+1] <= md_r[gi];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[QUO_BITS+1]) begin
      if (q_r[QUO_BITS][QUO_BITS-1]) begin
        nrm_r <= q_r[QUO_BITS];
        be1_r <= be_r[QUO_BITS];
      end else begin
        nrm_r <= {q_r[QUO_BITS][QUO_BITS-2:0], 1'b0};
        be1_r <= be_r[QUO_BITS] - 11'sd1;
      end
      st0_r    <= |rem_r[QUO_BITS];
      sgn1_r   <= sgn_r[QUO_BITS];
      spec1_r  <= spec_r[QUO_BITS];
      specv1_r <= specv_r[QUO_BITS];
    end
  end

  always_comb begin
    one_minus = 11'sd1 - be1_r;
    sh        = '0;
    wide      = '0;
    ns        = nrm_r;
    st        = st0_r;
    ef        = be1_r[7:0];
    up        = 1'b0;
    mag       = '0;
    if (spec1_r) begin
      quo_nxt = specv1_r;
    end else if (be1_r >= 11'sd255) begin
      quo_nxt = {sgn1_r, F_INF_MAG};
    end else begin
      if (be1_r <= 11'sd0) begin
        sh   = (one_minus > 11'sd31) ? 5'd31 : one_minus[4:0];
        wide = {nrm_r, 31'd0} >> sh;
        ns   = wide[57:31];
        st   = st0_r || (|wide[30:0]);
        ef   = 8'd0;
      end
      st      = st || ns[1] || ns[0];
      up      = ns[2] && (st || ns[3]);
      mag     = {ef, ns[25:3]} + {30'd0, up};
      quo_nxt = {sgn1_r, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en[QUO_BITS+2]) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

### hw/rtl/rubi_slab.sv
// One axis of the slab test: numerators, two divisions and the entry/exit ordering.
`timescale 1ns / 1ps
`default_nettype none
module rubi_slab
  import rubi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [SLAB_STAGES-1:0] en,
  input  wire logic [31:0]            thr,
  input  wire logic [31:0]            o,
  input  wire logic [31:0]            d,
  output logic [31:0]                 t_enter,
  output logic [31:0]                 t_exit
);

  logic [31:0] o_r, d_r;
  logic [31:0] d1_r;
  logic [4:0]  dlz1_r;
  logic        par1_r;
  dinfo_t      dinf2_r, dinf3_r, dinf4_r;
  logic [23:0] md_nxt;
  logic signed [9:0] edn_nxt;
  logic        par_nxt;

  logic [31:0] sum_lo, sum_hi, num_lo, num_hi, q_lo, q_hi;
  logic [31:0] enter_r, exit_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      o_r <= o;
      d_r <= d;
    end
  end

  assign par_nxt = !(f_ge({1'b0, d_r[30:0]}, thr) && (d_r[30:0] != 31'd0));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_r   <= d_r;
      dlz1_r <= lzc27({1'b0, d_r[22:0], 3'b000});
      par1_r <= par_nxt;
    end
  end

  always_comb begin
    if (d1_r[30:23] == 8'd0) begin
      md_nxt  = {1'b0, d1_r[22:0]} << dlz1_r;
      edn_nxt = 10'sd1 - $signed({5'd0, dlz1_r});
    end else begin
      md_nxt  = {1'b1, d1_r[22:0]};
      edn_nxt = $signed({2'b00, d1_r[30:23]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dinf2_r.par <= par1_r;
      dinf2_r.sgn <= d1_r[31];
      dinf2_r.inf <= (&d1_r[30:23]) && !(|d1_r[22:0]);
      dinf2_r.md  <= md_nxt;
      dinf2_r.edn <= edn_nxt;
    end
    if (en[3]) begin
      dinf3_r <= dinf2_r;
    end
    if (en[4]) begin
      dinf4_r <= dinf3_r;
    end
  end

  rubi_add1 u_add_lo (
    .clk (clk),
    .en  (en[ADD_STAGES:1]),
    .x   (o_r),
    .r   (sum_lo)
  );

  rubi_add1 u_add_hi (
    .clk (clk),
    .en  (en[ADD_STAGES:1]),
    .x   ({~o_r[31], o_r[30:0]}),
    .r   (sum_hi)
  );

  assign num_lo = (sum_lo[30:0] == 31'd0) ? 32'd0 : {~sum_lo[31], sum_lo[30:0]};
  assign num_hi = sum_hi;

  rubi_div u_div_lo (
    .clk  (clk),
    .en   (en[SWAP_STAGE-1:DIV_FIRST]),
    .num  (num_lo),
    .dinf (dinf4_r),
    .quo  (q_lo)
  );

  rubi_div u_div_hi (
    .clk  (clk),
    .en   (en[SWAP_STAGE-1:DIV_FIRST]),
    .num  (num_hi),
    .dinf (dinf4_r),
    .quo  (q_hi)
  );

  always_ff @(posedge clk) begin
    if (en[SWAP_STAGE]) begin
      if (f_gt(q_lo, q_hi)) begin
        enter_r <= q_hi;
        exit_r  <= q_lo;
      end else begin
        enter_r <= q_lo;
        exit_r  <= q_hi;
      end
    end
  end

  assign t_enter = enter_r;
  assign t_exit  = exit_r;

endmodule
`default_nettype wire

### hw/rtl/ray_unit_box_intersect.sv
// Top level: ray against the [-1,1] cube, slab test, fully pipelined.
// Takes one ray per cycle while the output side does not stall and returns t_near, t_far
// and hit. All three axes run side by side; the depth is set by the 27-stage quotient
// pipeline of each axis divider plus numerator adders, ordering and the reduction stages.
// Every stage holds a valid bit and only stalls when the stage after it is full, so
// bubbles are squeezed out and the input keeps taking items while a finished result
// waits, until every stage is full. The threshold register may be written only while
// the pipeline is empty; it resets to the single-precision value nearest 0.001.
`timescale 1ns / 1ps
`default_nettype none
module ray_unit_box_intersect
  import rubi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0]           thr_r;
  logic [NUM_STAGES-1:0] v_r, v_nxt, en;

  logic [31:0] ent_x, ent_y, ent_z, ext_x, ext_y, ext_z;
  logic [31:0] tn1_r, tf1_r, en2_r, ex2_r;
  logic [31:0] tn_r, tf_r;
  out_t        out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  assign en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
  for (genvar gk = 0; gk < NUM_STAGES - 1; gk++) begin : g_adv
    assign en[gk] = !v_r[gk] || en[gk+1];
  end

  assign v_nxt = {v_r[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NUM_STAGES-1];

  rubi_slab u_slab_x (
    .clk     (clk),
    .en      (en[SLAB_STAGES-1:0]),
    .thr     (thr_r),
    .o       (in_data.origin_x),
    .d       (in_data.dir_x),
    .t_enter (ent_x),
    .t_exit  (ext_x)
  );

  rubi_slab u_slab_y (
    .clk     (clk),
    .en      (en[SLAB_STAGES-1:0]),
    .thr     (thr_r),
    .o       (in_data.origin_y),
    .d       (in_data.dir_y),
    .t_enter (ent_y),
    .t_exit  (ext_y)
  );

  rubi_slab u_slab_z (
    .clk     (clk),
    .en      (en[SLAB_STAGES-1:0]),
    .thr     (thr_r),
    .o       (in_data.origin_z),
    .d       (in_data.dir_z),
    .t_enter (ent_z),
    .t_exit  (ext_z)
  );

  always_ff @(posedge clk) begin
    if (en[SLAB_STAGES]) begin
      tn1_r <= f_gt(ent_x, ent_y) ? ent_x : ent_y;
      tf1_r <= f_gt(ext_y, ext_x) ? ext_x : ext_y;
      en2_r <= ent_z;
      ex2_r <= ext_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[SLAB_STAGES+1]) begin
      tn_r <= f_gt(tn1_r, en2_r) ? tn1_r : en2_r;
      tf_r <= f_gt(ex2_r, tf1_r) ? tf1_r : ex2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[SLAB_STAGES+2]) begin
      out_r.hit    <= f_ge(tf_r, tn_r);
      out_r.t_near <= f_is_nan(tn_r) ? F_NAN : tn_r;
      out_r.t_far  <= f_is_nan(tf_r) ? F_NAN : tf_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### sim/ray_unit_box_intersect_test.sv
// Testbench for the ray/unit-box slab intersection pipeline with a float predictor.
`timescale 1ns / 1ps
module ray_unit_box_intersect_test;
  import rubi_pkg::*;

  localparam int RAND_PER_PHASE = 120;
  localparam int NUM_PHASES     = 7;
  localparam int DRAIN_CYCLES   = 60;
  localparam int STALL_CYCLES   = 400;
  localparam int CYCLE_LIMIT    = 2000000;

  typedef struct {
    in_t  ray;
    logic known;
    out_t res;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  logic [31:0] threshold;
  out_t        hits_pending[$];
  int          mismatches;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;
  vector_t     directed[$];
  logic [31:0] special[12];

  ray_unit_box_intersect u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic real sp_to_real(input logic [31:0] b);
    logic [63:0] d;
    logic [23:0] mm;
    int          e;
    if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, b[22:0], 29'd0};
    end else if (b[30:23] == 8'd0) begin
      if (b[22:0] == 23'd0) begin
        d = {b[31], 63'd0};
      end else begin
        mm = {1'b0, b[22:0]};
        e = -126;
        while (!mm[23]) begin
          mm = mm << 1;
          e--;
        end
        d = {b[31], 11'(e + 1023), mm[22:0], 29'd0};
      end
    end else begin
      d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic [30:0] mag;
    logic        inc;
    int          fe;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? F_NAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    fe = int'(d[62:52]) - 1023 + 127;
    if (fe >= 255) return {d[63], 8'hFF, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 54) return {d[63], 31'd0};
    keep = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    inc = (rem > half) || (rem == half && keep[0]);
    if (fe >= 1) mag = {8'(fe), keep[22:0]} + 31'(inc);
    else mag = keep[30:0] + 31'(inc);
    return {d[63], mag};
  endfunction

  function automatic void slab_axis(input logic [31:0] ob, input logic [31:0] db,
                                    output real enter, output real leave);
    real o, dv, mag, thr, lo, hi, a, b, t, inf;
    o = sp_to_real(ob);
    dv = sp_to_real(db);
    mag = sp_to_real({1'b0, db[30:0]});
    thr = sp_to_real(threshold);
    lo = sp_to_real(real_to_sp(-1.0 - o));
    hi = sp_to_real(real_to_sp(1.0 - o));
    if (mag >= thr && dv != 0.0) begin
      a = sp_to_real(real_to_sp(lo / dv));
      b = sp_to_real(real_to_sp(hi / dv));
    end else begin
      inf = $bitstoreal(64'h7FF0000000000000);
      a = lo * inf;
      b = hi * inf;
    end
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    enter = a;
    leave = b;
  endfunction

  function automatic out_t box_hit(input in_t ray);
    real  en0, en1, en2, ex0, ex1, ex2, tn, tf;
    out_t r;
    slab_axis(ray.origin_x, ray.dir_x, en0, ex0);
    slab_axis(ray.origin_y, ray.dir_y, en1, ex1);
    slab_axis(ray.origin_z, ray.dir_z, en2, ex2);
    tn = (en0 > en1) ? en0 : en1;
    tn = (tn > en2) ? tn : en2;
    tf = (ex0 < ex1) ? ex0 : ex1;
    tf = (tf < ex2) ? tf : ex2;
    r.hit = (tn <= tf);
    r.t_near = real_to_sp(tn);
    r.t_far = real_to_sp(tf);
    return r;
  endfunction

  function automatic logic [31:0] pick_float(input bit origin);
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return special[$urandom_range(11)];
    if (sel < 40) return $urandom;
    if (sel < 48) return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
    if (origin) return real_to_sp($urandom_range(8000) / 1000.0 - 4.0);
    return real_to_sp($urandom_range(4000) / 1000.0 - 2.0);
  endfunction

  function automatic in_t random_ray();
    in_t r;
    r.origin_x = pick_float(1'b1);
    r.origin_y = pick_float(1'b1);
    r.origin_z = pick_float(1'b1);
    r.dir_x = pick_float(1'b0);
    r.dir_y = pick_float(1'b0);
    r.dir_z = pick_float(1'b0);
    return r;
  endfunction

  task automatic send_ray(input in_t ray, input logic known, input out_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = ray;
    do @(posedge clk); while (!in_ready);
    hits_pending.push_back(known ? res : box_hit(ray));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (hits_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(input logic [31:0] ox, oy, oz, dx, dy, dz,
                         input logic known, input out_t res);
    vector_t v;
    v.ray = '{ox, oy, oz, dx, dy, dz};
    v.known = known;
    v.res = res;
    directed.push_back(v);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h at cycle %0d", what, want, got, cycles);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hits_pending.size() == 0) begin
        report("unexpected item", out_data.t_near, 32'd0);
      end else begin
        want = hits_pending.pop_front();
        if (out_data.hit !== want.hit) report("hit", 32'(out_data.hit), 32'(want.hit));
        if (out_data.t_near !== want.t_near) report("t_near", out_data.t_near, want.t_near);
        if (out_data.t_far !== want.t_far) report("t_far", out_data.t_far, want.t_far);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [31:0] thresholds[NUM_PHASES];
    logic [31:0] pos_one, neg_one, pos_inf, neg_inf;
    in_t         ray;
    vector_t     v;
    cycles = 0;
    mismatches = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    threshold = THR_RESET;
    send_idle_pct = 35;
    recv_idle_pct = 48;
    pos_one = 32'h3F800000;
    neg_one = 32'hBF800000;
    pos_inf = 32'h7F800000;
    neg_inf = 32'hFF800000;
    special = '{32'h00000000, 32'h80000000, pos_one, neg_one, pos_inf, neg_inf, F_NAN,
                32'h00000001, 32'h7F7FFFFF, THR_RESET, 32'h3A83126E, 32'hFFFFFFFF};
    thresholds = '{THR_RESET, 32'h00000000, 32'h3F000000, 32'hFFFFFFFF, 32'h7F800000,
                   32'h80000000, 32'($urandom)};

    add_row(0, 0, 0, pos_one, pos_one, pos_one, 1'b1, '{1'b1, neg_one, pos_one});
    add_row(0, 0, 0, 0, 0, 0, 1'b1, '{1'b1, neg_inf, pos_inf});
    add_row(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1,
            '{1'b1, neg_inf, pos_inf});
    add_row(0, 0, 0, neg_one, neg_one, neg_one, 1'b1, '{1'b1, neg_one, pos_one});
    add_row(F_NAN, F_NAN, F_NAN, pos_one, pos_one, pos_one, 1'b1, '{1'b0, F_NAN, F_NAN});
    add_row(32'h40400000, 0, 0, 0, pos_one, pos_one, 1'b1, '{1'b0, neg_one, neg_inf});
    add_row(pos_one, 0, 0, 0, pos_one, pos_one, 1'b0, '0);
    add_row(neg_one, neg_one, neg_one, 0, 0, 0, 1'b0, '0);
    add_row(0, 0, 0, THR_RESET, 32'h3A83126E, 32'hBA83126F, 1'b0, '0);
    add_row(0, 0, 0, F_NAN, pos_inf, neg_inf, 1'b0, '0);
    add_row(32'h7F7FFFFF, 32'hFF7FFFFF, 0, 32'h00000001, pos_one, pos_one, 1'b0, '0);
    add_row(pos_inf, neg_inf, 0, pos_one, pos_one, pos_one, 1'b0, '0);
    add_row(32'hFFFFFFFF, 32'h00000001, 32'h80000001, 32'h7F7FFFFF, 32'h00800000,
            32'hFFFFFFFF, 1'b0, '0);
    add_row(32'h3F000000, 32'hBF000000, 32'h3E800000, 32'h40000000, 32'hC0000000,
            32'h3F000000, 1'b0, '0);
    add_row(32'h40000000, 32'h40000000, 32'h40000000, neg_one, neg_one, neg_one, 1'b0, '0);
    add_row(32'h40000000, 0, 0, pos_one, 0, 0, 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 35 : (p < 4) ? 48 : 0;
      recv_idle_pct = (p < 2) ? 48 : (p < 4) ? 35 : 0;
      if (p != 0) write_threshold(thresholds[p]);
      if (p == 0) begin
        foreach (directed[i]) begin
          v = directed[i];
          send_ray(v.ray, v.known, v.res);
        end
      end
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        ray = random_ray();
        send_ray(ray, 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
